[hdl/dnsqar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dnsqar_pkg;

  // Receive buffer depth in bytes.
  localparam int unsigned MsgBytes   = 512;
  localparam int unsigned AddrW      = $clog2(MsgBytes);
  localparam int unsigned CntW       = $clog2(MsgBytes + 1);
  localparam int unsigned NextW      = $clog2(MsgBytes + 64 + 1);
  localparam int unsigned QendW      = CntW + 1;

  localparam int unsigned HdrBytes   = 12;
  localparam int unsigned IdHdrBytes = 6;
  localparam int unsigned MaxLabel   = 63;
  localparam int unsigned MaxName    = 255;
  localparam int unsigned QtailBytes = 4;
  localparam int unsigned AnsBytes   = 16;
  localparam int unsigned TtlSeconds = 60;

  localparam int unsigned LenW       = 9;
  localparam int unsigned VerdW      = 3;
  localparam int unsigned MinReply   = HdrBytes + 1 + QtailBytes + AnsBytes;
  localparam int unsigned MaxReply   = HdrBytes + MaxName + QtailBytes + AnsBytes;
  localparam int unsigned OutDataW   = 24;

  typedef enum logic [VerdW-1:0] {
    VerdictOk        = 3'd0,
    VerdictShort     = 3'd1,
    VerdictNotQuery  = 3'd2,
    VerdictOpcode    = 3'd3,
    VerdictNoQuest   = 3'd4,
    VerdictLabel     = 3'd5,
    VerdictNameLong  = 3'd6,
    VerdictTruncated = 3'd7
  } verdict_e;

  typedef enum logic {
    KindRecv  = 1'b0,
    KindFetch = 1'b1
  } kind_e;

  // Fixed reply header bytes 2..11 (ID bytes come from the query).
  function automatic logic [7:0] head_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd2:    b = 8'h84;
      4'd3:    b = 8'h80;
      4'd5:    b = 8'h01;
      4'd7:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Answer record up to RDLENGTH: pointer, type A, class IN, TTL, length 4.
  function automatic logic [7:0] ans_byte(input logic [3:0] k);
    logic [7:0] b;
    unique case (k)
      4'd0:    b = 8'hc0;
      4'd1:    b = 8'h0c;
      4'd3:    b = 8'h01;
      4'd5:    b = 8'h01;
      4'd9:    b = 8'(TtlSeconds);
      4'd11:   b = 8'h04;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hdl/dns_query_answer_responder.sv]
// Each transaction passes through the stage 1 register and then the output register
// before a result that it causes can be accepted.
// Throughput: one input transaction per cycle while results are taken; a stalled
// result holds the input once the middle stage is full.
// Reset: asynchronous, active low; clears receive state, any pending reply and
// the answer address. The query byte store and the saved header bytes are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dns_query_answer_responder (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,  // in_byte[7:0]
  input  wire logic                 s_axis_tuser,  // kind
  input  wire logic                 s_axis_tlast,  // in_last
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [dnsqar_pkg::OutDataW-1:0] m_axis_tdata,
  // reply_byte[7:0], verdict[10:8], reply_length[19:11], zero[23:20]
  output logic                      m_axis_tuser,  // is_reply_byte
  output logic                      m_axis_tlast   // reply_last
);
  import dnsqar_pkg::*;

  // configuration
  logic [31:0] router_q;

  // receive walk state
  logic [CntW-1:0]  rx_cnt_q, rx_cnt_d;
  logic [NextW-1:0] next_lbl_q, next_lbl_d;
  logic             name_fin_q, name_fin_d;
  logic [CntW-1:0]  name_end_q, name_end_d;
  logic             lbl_err_q, lbl_err_d;
  logic [7:0]       hdr_q [IdHdrBytes];
  logic [7:0]       hdr_d [IdHdrBytes];

  // reply state
  logic             pend_q, pend_d;
  logic [LenW-1:0]  size_q, size_d;
  logic [LenW-1:0]  fetch_q, fetch_d;

  // query byte store
  logic [7:0] mem_q [MsgBytes];
  logic [7:0] rdata_q;

  // stage 1
  logic             s1_valid_q, s1_valid_d;
  logic             s1_reply_q, s1_reply_d;
  logic             s1_sel_mem_q, s1_sel_mem_d;
  logic [7:0]       s1_byte_q, s1_byte_d;
  logic             s1_last_q, s1_last_d;
  verdict_e         s1_verd_q, s1_verd_d;
  logic [LenW-1:0]  s1_len_q, s1_len_d;

  // output register
  logic             out_valid_q;
  logic             out_reply_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;
  verdict_e         out_verd_q;
  logic [LenW-1:0]  out_len_q;

  logic advance, accept, is_recv, is_fetch, store_en;

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance || !s1_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_recv       = accept && (kind_e'(s_axis_tuser) == KindRecv);
  assign is_fetch      = accept && (kind_e'(s_axis_tuser) == KindFetch);
  assign store_en      = is_recv && (rx_cnt_q < CntW'(MsgBytes));

  always_comb begin
    logic             walk;
    logic [QendW-1:0] qend_chk;
    logic [QendW-1:0] qend;
    logic [QendW-1:0] idx;
    logic [QendW-1:0] kdiff;
    logic [3:0]       k;
    logic [15:0]      flags;
    verdict_e         v;
    logic [7:0]       cbyte;

    rx_cnt_d   = rx_cnt_q;
    next_lbl_d = next_lbl_q;
    name_fin_d = name_fin_q;
    name_end_d = name_end_q;
    lbl_err_d  = lbl_err_q;
    hdr_d      = hdr_q;
    pend_d     = pend_q;
    size_d     = size_q;
    fetch_d    = fetch_q;

    s1_valid_d   = 1'b0;
    s1_reply_d   = 1'b0;
    s1_sel_mem_d = 1'b0;
    s1_byte_d    = 8'h00;
    s1_last_d    = 1'b0;
    s1_verd_d    = VerdictOk;
    s1_len_d     = '0;

    v        = VerdictOk;
    cbyte    = 8'h00;
    qend_chk = '0;
    flags    = '0;
    walk     = 1'b0;

    // reply position decode for a fetch
    qend  = QendW'(name_end_q) + QendW'(QtailBytes);
    idx   = QendW'(fetch_q);
    kdiff = idx - qend;
    k     = kdiff[3:0];

    if (is_recv) begin
      pend_d = 1'b0;
      if (store_en) begin
        for (int j = 0; j < IdHdrBytes; j++) begin
          if (rx_cnt_q == CntW'(j)) hdr_d[j] = s_axis_tdata;
        end
        walk = !name_fin_q && !lbl_err_q && (rx_cnt_q >= CntW'(HdrBytes)) &&
               (NextW'(rx_cnt_q) == next_lbl_q);
        if (walk) begin
          if (s_axis_tdata == 8'h00) begin
            name_fin_d = 1'b1;
            name_end_d = rx_cnt_q + CntW'(1);
          end else if (s_axis_tdata > 8'(MaxLabel)) begin
            lbl_err_d = 1'b1;
          end else begin
            next_lbl_d = NextW'(rx_cnt_q) + NextW'(1) + NextW'(s_axis_tdata);
          end
        end
        rx_cnt_d = rx_cnt_q + CntW'(1);
      end

      if (s_axis_tlast) begin
        flags    = {hdr_d[2], hdr_d[3]};
        qend_chk = QendW'(name_end_d) + QendW'(QtailBytes);
        priority if (rx_cnt_d < CntW'(HdrBytes))                      v = VerdictShort;
        else if (flags[15])                                           v = VerdictNotQuery;
        else if (flags[14:11] != 4'd0)                                v = VerdictOpcode;
        else if ({hdr_d[4], hdr_d[5]} == 16'd0)                       v = VerdictNoQuest;
        else if (lbl_err_d)                                           v = VerdictLabel;
        else if (!name_fin_d)                                         v = VerdictTruncated;
        else if ((name_end_d - CntW'(HdrBytes)) > CntW'(MaxName))     v = VerdictNameLong;
        else if (qend_chk > QendW'(rx_cnt_d))                         v = VerdictTruncated;
        else                                                          v = VerdictOk;

        s1_valid_d = 1'b1;
        s1_verd_d  = v;
        if (v == VerdictOk) begin
          s1_len_d = LenW'(qend_chk + QendW'(AnsBytes));
          pend_d   = 1'b1;
          size_d   = LenW'(qend_chk + QendW'(AnsBytes));
          fetch_d  = '0;
        end else begin
          name_end_d = '0;
        end
        rx_cnt_d   = '0;
        next_lbl_d = NextW'(HdrBytes);
        name_fin_d = 1'b0;
        lbl_err_d  = 1'b0;
      end
    end else if (is_fetch && pend_q && (fetch_q < size_q)) begin
      priority if (idx < QendW'(2)) begin
        cbyte = fetch_q[0] ? hdr_q[1] : hdr_q[0];
      end else if (idx < QendW'(HdrBytes)) begin
        cbyte = head_byte(fetch_q[3:0]);
      end else if (idx < qend) begin
        cbyte = 8'h00;
      end else if (k < 4'd12) begin
        cbyte = ans_byte(k);
      end else begin
        unique case (k[1:0])
          2'd0: cbyte = router_q[31:24];
          2'd1: cbyte = router_q[23:16];
          2'd2: cbyte = router_q[15:8];
          2'd3: cbyte = router_q[7:0];
        endcase
      end
      s1_valid_d   = 1'b1;
      s1_reply_d   = 1'b1;
      s1_sel_mem_d = (idx >= QendW'(HdrBytes)) && (idx < qend);
      s1_byte_d    = cbyte;
      s1_last_d    = (fetch_q + LenW'(1)) == size_q;
      fetch_d      = fetch_q + LenW'(1);
      if (fetch_d >= size_q) pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      router_q    <= '0;
      rx_cnt_q    <= '0;
      next_lbl_q  <= NextW'(HdrBytes);
      name_fin_q  <= 1'b0;
      name_end_q  <= '0;
      lbl_err_q   <= 1'b0;
      pend_q      <= 1'b0;
      size_q      <= '0;
      fetch_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) router_q <= cfg_data_i;
      rx_cnt_q   <= rx_cnt_d;
      next_lbl_q <= next_lbl_d;
      name_fin_q <= name_fin_d;
      name_end_q <= name_end_d;
      lbl_err_q  <= lbl_err_d;
      pend_q     <= pend_d;
      size_q     <= size_d;
      fetch_q    <= fetch_d;
      if (s_axis_tready) s1_valid_q <= s1_valid_d;
      if (advance)       out_valid_q <= s1_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    if (s_axis_tready) begin
      s1_reply_q   <= s1_reply_d;
      s1_sel_mem_q <= s1_sel_mem_d;
      s1_byte_q    <= s1_byte_d;
      s1_last_q    <= s1_last_d;
      s1_verd_q    <= s1_verd_d;
      s1_len_q     <= s1_len_d;
    end
    if (advance) begin
      out_reply_q <= s1_reply_q;
      out_byte_q  <= s1_sel_mem_q ? rdata_q : s1_byte_q;
      out_last_q  <= s1_last_q;
      out_verd_q  <= s1_verd_q;
      out_len_q   <= s1_len_q;
    end
  end

  // query byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_en) mem_q[rx_cnt_q[AddrW-1:0]] <= s_axis_tdata;
    if (is_fetch) rdata_q <= mem_q[AddrW'(fetch_q)];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_reply_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(OutDataW - 8 - VerdW - LenW)'(0), out_len_q, out_verd_q, out_byte_q};

endmodule

`default_nettype wire

[hdl/dnsqar_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module dnsqar_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [dnsqar_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser,
  input wire logic                          m_axis_tlast
);
  import dnsqar_pkg::*;

  logic [7:0]      rbyte;
  logic [VerdW-1:0] verd;
  logic [LenW-1:0] rlen;

  assign rbyte = m_axis_tdata[7:0];
  assign verd  = m_axis_tdata[8 +: VerdW];
  assign rlen  = m_axis_tdata[8 + VerdW +: LenW];

  // a stalled transaction holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_verdict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tlast && rbyte == 8'h00)
    else $error("verdict carries reply byte fields");

  a_reply_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> verd == VerdW'(VerdictOk) && rlen == '0)
    else $error("reply byte carries verdict fields");

  a_reject_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && verd != VerdW'(VerdictOk) |-> rlen == '0)
    else $error("rejected query reports a reply length");

  a_ok_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && verd == VerdW'(VerdictOk) |->
      rlen >= LenW'(MinReply) && rlen <= LenW'(MaxReply))
    else $error("reply length out of range");

endmodule

bind dns_query_answer_responder dnsqar_checker u_dnsqar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
